// ===== hw/rtl/pire_pkg.sv =====
// Shared types and constants of the packet interval rate estimator.
// Holds opcodes, fixed field widths, controller states and the command/status structs.
// No dependencies.
`default_nettype none

package pire_pkg;

   // Fixed field widths
   localparam int unsigned OPCODE_W = 2;
   localparam int unsigned TIME_W   = 32;
   localparam int unsigned SEQ_W    = 4;
   localparam int unsigned RATE_W   = 20;

   // Request opcodes
   localparam logic [OPCODE_W-1:0] OP_ARRIVE = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_SEND   = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_QUERY  = 2'd2;

   // Sequence nibbles that mark a probe pair
   localparam logic [SEQ_W-1:0] SEQ_PROBE_START = 4'd0;
   localparam logic [SEQ_W-1:0] SEQ_PROBE_END   = 4'd1;

   // Rate limits and window reset values
   localparam logic [RATE_W-1:0] RATE_SCALE  = 20'd1000000;
   localparam logic [RATE_W-1:0] MIN_SPEED   = 20'd10;
   localparam logic [TIME_W-1:0] ARRIVE_INIT = 32'd1;
   localparam logic [TIME_W-1:0] PROBE_INIT  = 32'd1000;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_CAND_RD,
      ST_CAND_LD,
      ST_SCAN_RD,
      ST_SCAN_CNT,
      ST_RANK,
      ST_MEDIAN,
      ST_FLT_RD,
      ST_FLT_ACC,
      ST_PREP,
      ST_MEAN_WAIT,
      ST_MEAN_CHK,
      ST_BW_CHK,
      ST_RATE_WAIT,
      ST_NEXT_WIN,
      ST_OUT
   } ctrl_state_type;

   typedef enum logic [4:0] {
      DP_NOP,
      DP_QUERY_INIT,
      DP_CAND_RD,
      DP_CAND_LD,
      DP_SCAN_RD,
      DP_SCAN_CNT,
      DP_RANK,
      DP_MEDIAN,
      DP_FLT_RD,
      DP_FLT_ACC,
      DP_RECV_MIN,
      DP_RECV_MAX,
      DP_BW_SEED,
      DP_BW_MAX,
      DP_DIV_MEAN,
      DP_MEAN_LD,
      DP_DIV_RATE,
      DP_RATE_LD,
      DP_NEXT_WIN,
      DP_RSP_LOAD
   } dp_op_type;

   typedef struct packed {
      logic      arrive;
      logic      send;
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic idx_last;
      logic cand_last;
      logic win_probe;
      logic cnt_small;
      logic sum_zero;
      logic mean_zero;
      logic div_done;
      logic rsp_free;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== hw/rtl/pire_req_if.sv =====
// Request channel of the packet interval rate estimator: valid/ready plus event fields.
// Depends on pire_pkg.
`default_nettype none

interface pire_req_if import pire_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [TIME_W-1:0]   event_time;
   logic [SEQ_W-1:0]    seq_low;

   modport source (output valid, output opcode, output event_time, output seq_low,
                   input ready);
   modport sink   (input valid, input opcode, input event_time, input seq_low,
                   output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/pire_rsp_if.sv =====
// Response channel of the packet interval rate estimator: valid/ready plus estimates.
// Depends on pire_pkg.
`default_nettype none

interface pire_rsp_if import pire_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [RATE_W-1:0] recv_speed;
   logic [RATE_W-1:0] bandwidth;
   logic [RATE_W-1:0] min_send_gap;

   modport source (output valid, output recv_speed, output bandwidth, output min_send_gap,
                   input ready);
   modport sink   (input valid, input recv_speed, input bandwidth, input min_send_gap,
                   output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/packet_interval_rate_estimator.sv =====
// Packet interval rate estimator. Arrival and send requests are taken back to back while
// idle, even while a response waits. A query walks the arrival window and then the probe
// window, finding the median by ranking every entry against every other one (each
// comparison reads its entry through the registered window read port), then filtering and
// dividing on a shared one-bit-per-cycle divider. The divisions are skipped when too few
// arrival samples pass the band or the probe sum is zero, and the walk waits at its end
// while the output register still holds an untaken response. No request is taken during
// the walk. The response is held in an output register.
// Depends on pire_pkg, pire_req_if, pire_rsp_if, pire_ctrl and pire_dp.
`default_nettype none

module packet_interval_rate_estimator import pire_pkg::*; #(
   parameter int unsigned WINDOW_SIZE = 16
) (
   input logic        clock,
   input logic        reset,
   pire_req_if.sink   req_bus,
   pire_rsp_if.source rsp_bus
);

   dp_cmd_type    cmd;
   dp_status_type status;
   logic          req_ready;

   assign req_bus.ready = req_ready;

   pire_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_bus.valid),
      .req_opcode (req_bus.opcode),
      .status     (status),
      .req_ready  (req_ready),
      .cmd        (cmd)
   );

   pire_dp #(
      .WINDOW_SIZE (WINDOW_SIZE)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_event_time   (req_bus.event_time),
      .req_seq_low      (req_bus.seq_low),
      .rsp_ready        (rsp_bus.ready),
      .rsp_valid        (rsp_bus.valid),
      .rsp_recv_speed   (rsp_bus.recv_speed),
      .rsp_bandwidth    (rsp_bus.bandwidth),
      .rsp_min_send_gap (rsp_bus.min_send_gap)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/pire_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle, shared by all query divisions.
// Depends on pire_pkg only through the house import.
`default_nettype none

module pire_div import pire_pkg::*; #(
   parameter int unsigned DIV_W = 39
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [DIV_W-1:0] divisor,
   output logic [DIV_W-1:0] quotient,
   output logic             done
);

   localparam int unsigned STEP_W = $clog2(DIV_W);
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_W - 1);

   logic              busy_ff;
   logic              done_ff;
   logic [STEP_W-1:0] step_ff;
   logic [DIV_W-1:0]  rem_ff;
   logic [DIV_W-1:0]  quo_ff;
   logic [DIV_W-1:0]  dvs_ff;
   logic [DIV_W:0]    rem_sh;
   logic [DIV_W:0]    diff;

   // Shift in the next dividend bit and trial-subtract
   always_comb begin
      rem_sh = {rem_ff, quo_ff[DIV_W-1]};
      diff   = rem_sh - {1'b0, dvs_ff};
   end

   // Sequence the iterations
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else if (busy_ff) begin
         step_ff <= step_ff + 1'b1;
         if (step_ff == STEP_LAST) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   // Advance remainder and quotient
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         if (!diff[DIV_W]) begin
            rem_ff <= diff[DIV_W-1:0];
            quo_ff <= {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh[DIV_W-1:0];
            quo_ff <= {quo_ff[DIV_W-2:0], 1'b0};
         end
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/pire_dp.sv =====
// Datapath of the packet interval rate estimator: interval windows, rank search,
// band filter, divider and response register. Depends on pire_pkg and pire_div.
`default_nettype none

module pire_dp import pire_pkg::*; #(
   parameter int unsigned WINDOW_SIZE = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  dp_cmd_type        cmd,
   output dp_status_type     status,
   input  logic [TIME_W-1:0] req_event_time,
   input  logic [SEQ_W-1:0]  req_seq_low,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output logic [RATE_W-1:0] rsp_recv_speed,
   output logic [RATE_W-1:0] rsp_bandwidth,
   output logic [RATE_W-1:0] rsp_min_send_gap
);

   localparam int unsigned IDX_W = $clog2(WINDOW_SIZE);
   localparam int unsigned RNK_W = $clog2(WINDOW_SIZE + 1);
   localparam int unsigned CNT_W = $clog2(WINDOW_SIZE + 2);
   localparam int unsigned SUM_W = TIME_W + CNT_W + 1;
   localparam int unsigned DIV_W = SUM_W + 1;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW_SIZE - 1);
   localparam logic [RNK_W-1:0] RANK_LO  = RNK_W'(WINDOW_SIZE / 2 - 1);
   localparam logic [RNK_W-1:0] RANK_HI  = RNK_W'(WINDOW_SIZE / 2);
   localparam logic [CNT_W-1:0] CNT_HALF = CNT_W'(WINDOW_SIZE / 2);

   // Window storage
   logic [TIME_W-1:0]      arr_mem_ff [WINDOW_SIZE];
   logic [TIME_W-1:0]      prb_mem_ff [WINDOW_SIZE];
   logic [WINDOW_SIZE-1:0] arr_vld_ff;
   logic [WINDOW_SIZE-1:0] prb_vld_ff;
   logic [TIME_W-1:0]      arr_rd_ff;
   logic [TIME_W-1:0]      prb_rd_ff;
   logic                   arr_rv_ff;
   logic                   prb_rv_ff;

   // Event tracking
   logic [IDX_W-1:0]  arr_slot_ff;
   logic [IDX_W-1:0]  prb_slot_ff;
   logic [TIME_W-1:0] last_arr_ff;
   logic [TIME_W-1:0] probe_start_ff;
   logic [TIME_W-1:0] last_sent_ff;
   logic [RATE_W-1:0] min_gap_ff;

   // Query working registers
   logic              win_ff;
   logic [IDX_W-1:0]  i_ff;
   logic [IDX_W-1:0]  j_ff;
   logic [TIME_W-1:0] cand_ff;
   logic [RNK_W-1:0]  lt_ff;
   logic [RNK_W-1:0]  le_ff;
   logic [TIME_W-1:0] lo_ff;
   logic [TIME_W-1:0] hi_ff;
   logic [TIME_W-1:0] med_ff;
   logic [SUM_W-1:0]  sum_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [TIME_W-1:0] mean_ff;
   logic [RATE_W-1:0] recv_ff;
   logic [RATE_W-1:0] bw_ff;

   // Response register
   logic              rsp_valid_ff;
   logic [RATE_W-1:0] rsp_recv_ff;
   logic [RATE_W-1:0] rsp_bw_ff;
   logic [RATE_W-1:0] rsp_gap_ff;

   logic [TIME_W-1:0] arr_gap;
   logic [TIME_W-1:0] prb_gap;
   logic [TIME_W-1:0] send_gap;
   logic              probe_end;
   logic [IDX_W-1:0]  rd_addr;
   logic [TIME_W-1:0] rdata;
   logic [TIME_W:0]   med_sum;
   logic [TIME_W+2:0] band_hi;
   logic [TIME_W-1:0] band_lo;
   logic              in_band;
   logic              div_start;
   logic [DIV_W-1:0]  div_num;
   logic [DIV_W-1:0]  div_den;
   logic [DIV_W-1:0]  div_quo;
   logic              div_done;
   logic [DIV_W-1:0]  bw_num;
   logic [DIV_W-1:0]  spd_num;
   logic [RATE_W-1:0] rate_q;

   // Event intervals, modulo 2^32
   always_comb begin
      arr_gap   = req_event_time - last_arr_ff;
      prb_gap   = req_event_time - probe_start_ff;
      send_gap  = req_event_time - last_sent_ff;
      probe_end = (req_seq_low == SEQ_PROBE_END);
   end

   // Track slots, timestamps, valid bits and the minimum send interval
   always_ff @(posedge clock) begin
      if (reset) begin
         arr_vld_ff     <= '0;
         prb_vld_ff     <= '0;
         arr_slot_ff    <= '0;
         prb_slot_ff    <= '0;
         last_arr_ff    <= '0;
         probe_start_ff <= '0;
         last_sent_ff   <= '0;
         min_gap_ff     <= RATE_SCALE;
      end else begin
         if (cmd.arrive) begin
            arr_vld_ff[arr_slot_ff] <= 1'b1;
            arr_slot_ff <= (arr_slot_ff == IDX_LAST) ? '0 : arr_slot_ff + 1'b1;
            last_arr_ff <= req_event_time;
            if (req_seq_low == SEQ_PROBE_START) begin
               probe_start_ff <= req_event_time;
            end else if (probe_end) begin
               prb_vld_ff[prb_slot_ff] <= 1'b1;
               prb_slot_ff <= (prb_slot_ff == IDX_LAST) ? '0 : prb_slot_ff + 1'b1;
            end
         end
         if (cmd.send) begin
            if (send_gap != '0 &&
                send_gap < {{(TIME_W - RATE_W){1'b0}}, min_gap_ff}) begin
               min_gap_ff <= send_gap[RATE_W-1:0];
            end
            last_sent_ff <= req_event_time;
         end
      end
   end

   // Write and read the windows; an unwritten entry reads as its reset value
   assign rd_addr = (cmd.op == DP_CAND_RD) ? i_ff : j_ff;

   always_ff @(posedge clock) begin
      if (cmd.arrive) begin
         arr_mem_ff[arr_slot_ff] <= arr_gap;
         if (probe_end) begin
            prb_mem_ff[prb_slot_ff] <= prb_gap;
         end
      end
      arr_rd_ff <= arr_mem_ff[rd_addr];
      prb_rd_ff <= prb_mem_ff[rd_addr];
      arr_rv_ff <= arr_vld_ff[rd_addr];
      prb_rv_ff <= prb_vld_ff[rd_addr];
   end

   always_comb begin
      if (win_ff) begin
         rdata = prb_rv_ff ? prb_rd_ff : PROBE_INIT;
      end else begin
         rdata = arr_rv_ff ? arr_rd_ff : ARRIVE_INIT;
      end
   end

   // Median and band limits
   always_comb begin
      med_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
      band_hi = {med_ff, 3'b000};
      band_lo = med_ff >> 3;
      in_band = ({3'b000, rdata} < band_hi) && (rdata > band_lo);
   end

   // Division operands and rate clamp
   always_comb begin
      bw_num  = DIV_W'(cnt_ff) * DIV_W'(RATE_SCALE) + DIV_W'(sum_ff) - DIV_W'(1);
      spd_num = DIV_W'(RATE_SCALE) + DIV_W'(mean_ff) - DIV_W'(1);
      div_start = (cmd.op == DP_DIV_MEAN) || (cmd.op == DP_DIV_RATE);
      if (cmd.op == DP_DIV_MEAN) begin
         div_num = DIV_W'(sum_ff);
         div_den = DIV_W'(cnt_ff);
      end else if (win_ff) begin
         div_num = bw_num;
         div_den = DIV_W'(sum_ff);
      end else begin
         div_num = spd_num;
         div_den = DIV_W'(mean_ff);
      end
      rate_q = (div_quo > DIV_W'(RATE_SCALE)) ? RATE_SCALE : div_quo[RATE_W-1:0];
   end

   pire_div #(
      .DIV_W (DIV_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .quotient (div_quo),
      .done     (div_done)
   );

   // Window select and scan indexes
   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= 1'b0;
         i_ff   <= '0;
         j_ff   <= '0;
      end else begin
         case (cmd.op)
            DP_QUERY_INIT: begin
               win_ff <= 1'b0;
               i_ff   <= '0;
            end
            DP_NEXT_WIN: begin
               win_ff <= 1'b1;
               i_ff   <= '0;
            end
            DP_CAND_LD, DP_MEDIAN: begin
               j_ff <= '0;
            end
            DP_SCAN_CNT, DP_FLT_ACC: begin
               if (j_ff != IDX_LAST) begin
                  j_ff <= j_ff + 1'b1;
               end
            end
            DP_RANK: begin
               if (i_ff != IDX_LAST) begin
                  i_ff <= i_ff + 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Rank search, band filter and rate results
   always_ff @(posedge clock) begin
      case (cmd.op)
         DP_CAND_LD: begin
            cand_ff <= rdata;
            lt_ff   <= '0;
            le_ff   <= '0;
         end
         DP_SCAN_CNT: begin
            if (rdata < cand_ff) begin
               lt_ff <= lt_ff + 1'b1;
            end
            if (rdata <= cand_ff) begin
               le_ff <= le_ff + 1'b1;
            end
         end
         DP_RANK: begin
            if (lt_ff <= RANK_LO && RANK_LO < le_ff) begin
               lo_ff <= cand_ff;
            end
            if (lt_ff <= RANK_HI && RANK_HI < le_ff) begin
               hi_ff <= cand_ff;
            end
         end
         DP_MEDIAN: begin
            med_ff <= med_sum[TIME_W:1];
            sum_ff <= '0;
            cnt_ff <= '0;
         end
         DP_FLT_ACC: begin
            if (in_band) begin
               sum_ff <= sum_ff + SUM_W'(rdata);
               cnt_ff <= cnt_ff + 1'b1;
            end
         end
         DP_BW_SEED: begin
            sum_ff <= sum_ff + SUM_W'(med_ff);
            cnt_ff <= cnt_ff + 1'b1;
         end
         DP_RECV_MIN: begin
            recv_ff <= MIN_SPEED;
         end
         DP_RECV_MAX: begin
            recv_ff <= RATE_SCALE;
         end
         DP_BW_MAX: begin
            bw_ff <= RATE_SCALE;
         end
         DP_MEAN_LD: begin
            mean_ff <= div_quo[TIME_W-1:0];
         end
         DP_RATE_LD: begin
            if (win_ff) begin
               bw_ff <= rate_q;
            end else begin
               recv_ff <= (rate_q < MIN_SPEED) ? MIN_SPEED : rate_q;
            end
         end
         default: begin
         end
      endcase
   end

   // Hold the response until the sink takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == DP_RSP_LOAD) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == DP_RSP_LOAD) begin
         rsp_recv_ff <= recv_ff;
         rsp_bw_ff   <= bw_ff;
         rsp_gap_ff  <= min_gap_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_recv_speed   = rsp_recv_ff;
   assign rsp_bandwidth    = rsp_bw_ff;
   assign rsp_min_send_gap = rsp_gap_ff;

   // Status back to the controller
   always_comb begin
      status.idx_last  = (j_ff == IDX_LAST);
      status.cand_last = (i_ff == IDX_LAST);
      status.win_probe = win_ff;
      status.cnt_small = (cnt_ff <= CNT_HALF);
      status.sum_zero  = (sum_ff == '0);
      status.mean_zero = (mean_ff == '0);
      status.div_done  = div_done;
      status.rsp_free  = !rsp_valid_ff || rsp_ready;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/pire_ctrl.sv =====
// Controller of the packet interval rate estimator: takes requests and sequences
// the query walk over both windows. Depends on pire_pkg.
`default_nettype none

module pire_ctrl import pire_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [OPCODE_W-1:0] req_opcode,
   input  dp_status_type       status,
   output logic                req_ready,
   output dp_cmd_type          cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and datapath commands
   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      cmd.arrive = 1'b0;
      cmd.send   = 1'b0;
      cmd.op     = DP_NOP;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (req_opcode)
                  OP_ARRIVE: cmd.arrive = 1'b1;
                  OP_SEND:   cmd.send   = 1'b1;
                  OP_QUERY: begin
                     cmd.op   = DP_QUERY_INIT;
                     state_in = ST_CAND_RD;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_CAND_RD: begin
            cmd.op   = DP_CAND_RD;
            state_in = ST_CAND_LD;
         end
         ST_CAND_LD: begin
            cmd.op   = DP_CAND_LD;
            state_in = ST_SCAN_RD;
         end
         ST_SCAN_RD: begin
            cmd.op   = DP_SCAN_RD;
            state_in = ST_SCAN_CNT;
         end
         ST_SCAN_CNT: begin
            cmd.op   = DP_SCAN_CNT;
            state_in = status.idx_last ? ST_RANK : ST_SCAN_RD;
         end
         ST_RANK: begin
            cmd.op   = DP_RANK;
            state_in = status.cand_last ? ST_MEDIAN : ST_CAND_RD;
         end
         ST_MEDIAN: begin
            cmd.op   = DP_MEDIAN;
            state_in = ST_FLT_RD;
         end
         ST_FLT_RD: begin
            cmd.op   = DP_FLT_RD;
            state_in = ST_FLT_ACC;
         end
         ST_FLT_ACC: begin
            cmd.op   = DP_FLT_ACC;
            state_in = status.idx_last ? ST_PREP : ST_FLT_RD;
         end
         ST_PREP: begin
            if (status.win_probe) begin
               cmd.op   = DP_BW_SEED;
               state_in = ST_BW_CHK;
            end else if (status.cnt_small) begin
               cmd.op   = DP_RECV_MIN;
               state_in = ST_NEXT_WIN;
            end else begin
               cmd.op   = DP_DIV_MEAN;
               state_in = ST_MEAN_WAIT;
            end
         end
         ST_MEAN_WAIT: begin
            if (status.div_done) begin
               cmd.op   = DP_MEAN_LD;
               state_in = ST_MEAN_CHK;
            end
         end
         ST_MEAN_CHK: begin
            if (status.mean_zero) begin
               cmd.op   = DP_RECV_MAX;
               state_in = ST_NEXT_WIN;
            end else begin
               cmd.op   = DP_DIV_RATE;
               state_in = ST_RATE_WAIT;
            end
         end
         ST_BW_CHK: begin
            if (status.sum_zero) begin
               cmd.op   = DP_BW_MAX;
               state_in = ST_OUT;
            end else begin
               cmd.op   = DP_DIV_RATE;
               state_in = ST_RATE_WAIT;
            end
         end
         ST_RATE_WAIT: begin
            if (status.div_done) begin
               cmd.op   = DP_RATE_LD;
               state_in = status.win_probe ? ST_OUT : ST_NEXT_WIN;
            end
         end
         ST_NEXT_WIN: begin
            cmd.op   = DP_NEXT_WIN;
            state_in = ST_CAND_RD;
         end
         ST_OUT: begin
            if (status.rsp_free) begin
               cmd.op   = DP_RSP_LOAD;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire
